@@ rtl/edrle_pkg.sv @@
// ----------------------------------------------------------------------------
// edrle_pkg
// Shared constants and the command type passed from the run tracker to the
// byte expander of the 0xED escape run-length encoder.
// ----------------------------------------------------------------------------
package edrle_pkg;

  localparam logic [7:0] ESC_BYTE      = 8'hED;
  localparam logic [7:0] MIN_RUN_PLAIN = 8'd5;
  localparam logic [7:0] MIN_RUN_ESC   = 8'd2;
  localparam logic [7:0] RUN_CAP       = 8'd255;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One closed run: either literal bytes (length below the threshold, so at
  // most four) or the escape sequence ED ED length value.
  typedef struct packed {
    logic [7:0] len;
    logic [7:0] val;
    logic       enc;
  } run_t;

  // Everything one input item produces: a closed run, a forced literal and
  // the end-of-page flush of the run left open.
  typedef struct packed {
    run_t       first;
    logic       lit_en;
    logic [7:0] lit_val;
    run_t       tail;
    logic       eop;
  } cmd_t;

  // Encoded runs reach the threshold; shorter ones go out as literals.
  function automatic logic run_enc(input logic [7:0] len, input logic [7:0] val);
    logic [7:0] need;
    need = (val == ESC_BYTE) ? MIN_RUN_ESC : MIN_RUN_PLAIN;
    return (len >= need);
  endfunction

  // Bytes a run puts on the stream.
  function automatic logic [2:0] run_cnt(input run_t r);
    return r.enc ? 3'd4 : r.len[2:0];
  endfunction

endpackage

@@ rtl/edrle_front.sv @@
// ----------------------------------------------------------------------------
// edrle_front
// Tracks the open run and turns each accepted item into a command for the
// byte expander. Items that only extend a run produce no command.
// ----------------------------------------------------------------------------
module edrle_front
  import edrle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_page,
  output logic       push,
  output cmd_t       cmd
);

  logic [7:0] run_value_r, run_value_nxt;
  logic [7:0] run_length_r, run_length_nxt;
  logic       extend, force_lit;
  logic [7:0] open_len, open_val;

  always_comb begin
    extend    = (run_length_r != 8'd0) && (data_byte == run_value_r) &&
                (run_length_r < RUN_CAP);
    force_lit = !extend && (run_length_r != 8'd0) && (run_value_r == ESC_BYTE) &&
                (data_byte != ESC_BYTE);

    cmd         = '0;
    cmd.eop     = end_of_page;
    cmd.lit_val = data_byte;

    if (extend) begin
      open_len = run_length_r + 8'd1;
      open_val = run_value_r;
    end else begin
      cmd.first.len = run_length_r;
      cmd.first.val = run_value_r;
      cmd.first.enc = run_enc(run_length_r, run_value_r);
      cmd.lit_en    = force_lit;
      // The byte after an escape run is sent as is and opens nothing.
      open_len = force_lit ? 8'd0 : 8'd1;
      open_val = data_byte;
    end

    if (end_of_page) begin
      cmd.tail.len = open_len;
      cmd.tail.val = open_val;
      cmd.tail.enc = run_enc(open_len, open_val);
    end

    push = accept && (end_of_page || (!extend && (run_length_r != 8'd0)));

    run_value_nxt  = run_value_r;
    run_length_nxt = run_length_r;
    if (accept) begin
      run_value_nxt  = end_of_page ? 8'd0 : open_val;
      run_length_nxt = end_of_page ? 8'd0 : open_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_value_r  <= 8'd0;
      run_length_r <= 8'd0;
    end else begin
      run_value_r  <= run_value_nxt;
      run_length_r <= run_length_nxt;
    end
  end

endmodule

@@ rtl/edrle_fifo.sv @@
// ----------------------------------------------------------------------------
// edrle_fifo
// Short first-word-fall-through queue of commands between the run tracker
// and the byte expander.
// ----------------------------------------------------------------------------
module edrle_fifo
  import edrle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic full,
  output logic empty
);

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;

  assign full   = (count_r == (QAW+1)'(QDEPTH));
  assign empty  = (count_r == '0);
  assign rd_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (QAW+1)'(1);
        2'b01:   count_r <= count_r - (QAW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/edrle_back.sv @@
// ----------------------------------------------------------------------------
// edrle_back
// Expands queued commands into compressed bytes in an output register, one per
// cycle unless stalled, and keeps the running compressed length of the page.
// ----------------------------------------------------------------------------
module edrle_back
  import edrle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tlast
);

  typedef enum logic [1:0] {PH_FIRST, PH_LIT, PH_TAIL} phase_t;

  phase_t      ph_r, ph_eff, ph_next;
  logic [1:0]  idx_r;
  logic [15:0] count_r;
  logic        out_valid_r, out_last_r;
  logic [7:0]  out_byte_r;
  logic [15:0] out_total_r;

  logic [2:0]  cnt_first, cnt_tail, cnt_eff;
  logic        has_first, has_tail;
  run_t        run_eff;
  logic [7:0]  byte_nxt;
  logic        advance, phase_done, cmd_done;
  logic [15:0] count_inc;

  assign count_inc = count_r + 16'd1;

  always_comb begin
    cnt_first = run_cnt(q_cmd.first);
    cnt_tail  = run_cnt(q_cmd.tail);
    has_first = (cnt_first != 3'd0);
    has_tail  = (cnt_tail != 3'd0);

    // Skip phases with nothing to send.
    case (ph_r)
      PH_FIRST: ph_eff = has_first ? PH_FIRST : (q_cmd.lit_en ? PH_LIT : PH_TAIL);
      PH_LIT:   ph_eff = q_cmd.lit_en ? PH_LIT : PH_TAIL;
      default:  ph_eff = PH_TAIL;
    endcase

    run_eff = (ph_eff == PH_FIRST) ? q_cmd.first : q_cmd.tail;
    cnt_eff = (ph_eff == PH_LIT) ? 3'd1 : run_cnt(run_eff);

    if (ph_eff == PH_LIT) begin
      byte_nxt = q_cmd.lit_val;
    end else if (run_eff.enc) begin
      case (idx_r)
        2'd0, 2'd1: byte_nxt = ESC_BYTE;
        2'd2:       byte_nxt = run_eff.len;
        default:    byte_nxt = run_eff.val;
      endcase
    end else begin
      byte_nxt = run_eff.val;
    end

    phase_done = ({1'b0, idx_r} == cnt_eff - 3'd1);

    case (ph_eff)
      PH_FIRST: begin
        ph_next  = q_cmd.lit_en ? PH_LIT : PH_TAIL;
        cmd_done = phase_done && !q_cmd.lit_en && !has_tail;
      end
      PH_LIT: begin
        ph_next  = PH_TAIL;
        cmd_done = phase_done && !has_tail;
      end
      default: begin
        ph_next  = PH_FIRST;
        cmd_done = phase_done;
      end
    endcase

    advance = !q_empty && (!out_valid_r || out_tready);
    q_pop   = advance && cmd_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_FIRST;
      idx_r       <= 2'd0;
      count_r     <= 16'd0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_byte_r  <= 8'd0;
      out_total_r <= 16'd0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= byte_nxt;
        out_total_r <= count_inc;
        out_last_r  <= cmd_done && q_cmd.eop;
        count_r     <= (cmd_done && q_cmd.eop) ? 16'd0 : count_inc;
        if (cmd_done) begin
          ph_r  <= PH_FIRST;
          idx_r <= 2'd0;
        end else if (phase_done) begin
          ph_r  <= ph_next;
          idx_r <= 2'd0;
        end else begin
          ph_r  <= ph_eff;
          idx_r <= idx_r + 2'd1;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, out_byte_r};
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/ed_escape_rle_encoder.sv @@
// ----------------------------------------------------------------------------
// ed_escape_rle_encoder
// Run-length encoder with 0xED as escape byte, one page byte per input item
// and one compressed byte per output item.
// ----------------------------------------------------------------------------
// Each item's command passes through the command queue to the output register.
// Throughput: one input item per cycle while the 4-entry command queue has
// room; the expander sends one byte per cycle when not stalled, 0 to 5 bytes
// per item, so the output byte rate sets the sustained item rate.
// Reset: synchronous, active low; clears run state, queue and page byte count.
module ed_escape_rle_encoder
  import edrle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_page
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] code_byte, [23:8] total_length
  output logic        out_tlast   // last_byte
);

  logic accept, push, pop, full, empty;
  cmd_t wr_cmd, rd_cmd;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  edrle_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_tdata),
    .end_of_page (in_tlast),
    .push        (push),
    .cmd         (wr_cmd)
  );

  edrle_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .full   (full),
    .empty  (empty)
  );

  edrle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (empty),
    .q_cmd      (rd_cmd),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
